FILE: src/tmcw_pkg.sv
// Shared types and constants for the text-mode console writer.
// No dependencies; the top level and the bench take names from here by scope.
package tmcw_pkg;

    localparam int CODE_W = 9;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
    localparam logic [7:0]        ATTR_NORMAL    = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0720;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CODE_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_COPY,
        ST_ZERO
    } t_state;

endpackage

FILE: src/tmcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/text_mode_console_writer.sv
// Top level of the text-mode console writer: sequencer, cursor and cell store.
// Depends on tmcw_pkg and tmcw_ram.
//
// Usage: raise start with a command word while busy is low; the word is taken
// at that edge and busy stays high until the cycle in which its result word is
// shown. Every command
// gives exactly one result word, shown on o_result for one cycle with o_done
// high; the receiver cannot stall it, so capture it on that edge. A read
// answers from ST_READ. A put of an ordinary character, newline or backspace
// passes ST_CHECK and, with no scroll, answers from there. A put that lands
// the cursor on the scroll row also walks the cell store once: it moves the
// rows up, then clears each cell from the new cursor to the end of row
// SCROLL_ROW-1 (always COLUMNS cells, since the cursor drops to the start of
// that row), then writes the blank under the cursor. The cell store has a
// single write port, which takes one cell a cycle. After reset the block
// stays busy while it zeroes the store.
module text_mode_console_writer #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROW  = 24,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  tmcw_pkg::t_in_word  i_cmd,
    output logic                busy,
    output logic                o_done,
    output tmcw_pkg::t_out_word o_result
);

    localparam int STORE = COLUMNS * SCREEN_ROWS;
    localparam int LIMIT = SCROLL_ROW * COLUMNS;
    localparam int MOVED = LIMIT - COLUMNS;
    localparam int CW    = $clog2(STORE + 1);
    localparam int AW    = $clog2(STORE);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int RW    = $clog2(SCROLL_ROW + 1);
    localparam int IW    = (CW > tmcw_pkg::IDX_W) ? CW : tmcw_pkg::IDX_W;

    // Sequencer and cursor state
    tmcw_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_cursor, n_cursor;
    logic [COLW-1:0]     r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_idx, n_idx;     // sweep counter for clear/copy/zero
    logic [CW-1:0]       r_wa, n_wa;       // write address of the pending copy
    logic                r_pend, n_pend;   // copy read in flight
    logic                r_rd_ok, n_rd_ok; // read address inside the store
    logic                r_done, n_done;
    tmcw_pkg::t_out_word r_result, n_result;

    // Cell store ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tmcw_pkg::CELL_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tmcw_pkg::CELL_W-1:0] ram_rdata;

    // Shared index incrementer used by every sweep
    logic [CW-1:0]               idx_inc;
    logic                        accept;

    assign idx_inc = r_idx + CW'(1);
    assign accept  = start && (r_state == tmcw_pkg::ST_IDLE);

    tmcw_ram #(
        .WIDTH (tmcw_pkg::CELL_W),
        .DEPTH (STORE)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tmcw_pkg::ST_CLEAR;
            r_cursor <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_row    <= n_row;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_done   <= n_done;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge i_clk) begin
        r_wa     <= n_wa;
        r_rd_ok  <= n_rd_ok;
        r_result <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_col     = r_col;
        n_row     = r_row;
        n_idx     = r_idx;
        n_wa      = r_wa;
        n_pend    = r_pend;
        n_rd_ok   = r_rd_ok;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_cursor[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];

        unique case (r_state)
            // Zero every cell once after reset
            tmcw_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                n_idx     = idx_inc;
                if (r_idx == CW'(STORE - 1)) begin
                    n_state = tmcw_pkg::ST_IDLE;
                end
            end

            tmcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == tmcw_pkg::OP_READ) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(i_cmd.cell_index);
                        n_rd_ok   = IW'(i_cmd.cell_index) < IW'(STORE);
                        n_state   = tmcw_pkg::ST_READ;
                    end else begin
                        n_state = tmcw_pkg::ST_CHECK;
                        priority if (i_cmd.char_code == tmcw_pkg::CODE_NEWLINE) begin
                            // Jump to the start of the next row
                            n_cursor = r_cursor + CW'(COLUMNS) - CW'(r_col);
                            n_col    = '0;
                            n_row    = r_row + RW'(1);
                        end else if (i_cmd.char_code == tmcw_pkg::CODE_BACKSPACE) begin
                            // Step back one cell, stop at the origin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - CW'(1);
                                if (r_col == '0) begin
                                    n_col = COLW'(COLUMNS - 1);
                                    n_row = r_row - RW'(1);
                                end else begin
                                    n_col = r_col - COLW'(1);
                                end
                            end
                        end else begin
                            // Store the character and advance
                            ram_we    = 1'b1;
                            ram_wdata = {tmcw_pkg::ATTR_NORMAL, i_cmd.char_code[7:0]};
                            n_cursor  = r_cursor + CW'(1);
                            if (r_col == COLW'(COLUMNS - 1)) begin
                                n_col = '0;
                                n_row = r_row + RW'(1);
                            end else begin
                                n_col = r_col + COLW'(1);
                            end
                        end
                    end
                end
            end

            // Decide on a scroll, otherwise drop the blank and finish
            tmcw_pkg::ST_CHECK: begin
                if (r_row == RW'(SCROLL_ROW)) begin
                    n_cursor = r_cursor - CW'(COLUMNS);
                    n_row    = r_row - RW'(1);
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_state  = tmcw_pkg::ST_COPY;
                end else begin
                    ram_we                = 1'b1;
                    ram_wdata             = tmcw_pkg::BLANK_CELL;
                    n_done                = 1'b1;
                    n_result.cursor_pos   = tmcw_pkg::IDX_W'(r_cursor);
                    n_result.cell_data    = '0;
                    n_state               = tmcw_pkg::ST_IDLE;
                end
            end

            tmcw_pkg::ST_READ: begin
                n_done              = 1'b1;
                n_result.cursor_pos = tmcw_pkg::IDX_W'(r_cursor);
                n_result.cell_data  = r_rd_ok ? ram_rdata : '0;
                n_state             = tmcw_pkg::ST_IDLE;
            end

            // Move rows up: read one row ahead, write the cell fetched last cycle
            tmcw_pkg::ST_COPY: begin
                ram_we    = r_pend;
                ram_waddr = r_wa[AW-1:0];
                ram_wdata = ram_rdata;
                if (r_idx != CW'(MOVED)) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + CW'(COLUMNS));
                    n_wa      = r_idx;
                    n_pend    = 1'b1;
                    n_idx     = idx_inc;
                end else begin
                    n_pend  = 1'b0;
                    n_idx   = r_cursor;
                    n_state = tmcw_pkg::ST_ZERO;
                end
            end

            // Clear from the cursor to the end of the last scrolled row,
            // then write the blank and report
            tmcw_pkg::ST_ZERO: begin
                ram_we = 1'b1;
                if (r_idx != CW'(LIMIT)) begin
                    ram_waddr = r_idx[AW-1:0];
                    n_idx     = idx_inc;
                end else begin
                    ram_wdata           = tmcw_pkg::BLANK_CELL;
                    n_done              = 1'b1;
                    n_result.cursor_pos = tmcw_pkg::IDX_W'(r_cursor);
                    n_result.cell_data  = '0;
                    n_state             = tmcw_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != tmcw_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // An accepted word keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    // A result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without work in flight");

    // Between items the cursor sits above the scroll row
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmcw_pkg::ST_IDLE) |-> (r_cursor < CW'(LIMIT) && r_row < RW'(SCROLL_ROW)))
        else $error("cursor beyond the scroll limit while idle");

    // The column counter never leaves the row
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COLW'(COLUMNS - 1))
        else $error("column counter out of range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for text_mode_console_writer: a directed table, then random traffic.
// Depends on tmcw_pkg and the RTL under src; a behavioral screen mirror predicts each word.
module tb;

    localparam int COLUMNS      = 80;
    localparam int SCROLL_ROW   = 24;
    localparam int SCREEN_ROWS  = 25;
    localparam int CELLS        = COLUMNS * SCREEN_ROWS;
    localparam int SCROLL_LIMIT = SCROLL_ROW * COLUMNS;
    localparam int INDEX_MAX    = (1 << tmcw_pkg::IDX_W) - 1;
    localparam int RANDOM_WORDS = 600;

    // One row of the directed table. Where typed is set, want is the literal
    // answer; otherwise the screen mirror supplies it.
    typedef struct {
        tmcw_pkg::t_in_word  cmd;
        bit                  typed;
        tmcw_pkg::t_out_word want;
    } t_table_row;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    tmcw_pkg::t_in_word  i_cmd   = '0;
    logic                busy;
    logic                o_done;
    tmcw_pkg::t_out_word o_result;

    // Behavioral copy of the cell store and cursor.
    logic [tmcw_pkg::CELL_W-1:0] screen_mirror [CELLS];
    int                          mirror_cursor;
    tmcw_pkg::t_out_word         awaited_words [$];

    int put_count;
    int read_count;
    int scroll_count;
    int checked_count;
    int error_count;

    text_mode_console_writer #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROW  (SCROLL_ROW),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one command word to the mirror and return the result word it yields.
    function automatic tmcw_pkg::t_out_word console_step(input tmcw_pkg::t_in_word w);
        tmcw_pkg::t_out_word r;
        int                  pos;
        int                  i;
        r = '0;
        if (w.opcode == tmcw_pkg::OP_PUT) begin
            pos = mirror_cursor;
            if (w.char_code == tmcw_pkg::CODE_NEWLINE) begin
                pos = pos + COLUMNS - pos % COLUMNS;
            end else if (w.char_code == tmcw_pkg::CODE_BACKSPACE) begin
                if (pos > 0) pos = pos - 1;
            end else begin
                // codes above the backspace code keep only their low byte
                screen_mirror[pos] = {tmcw_pkg::ATTR_NORMAL, w.char_code[7:0]};
                pos = pos + 1;
            end
            mirror_cursor = pos;
            // Cursor landed on the scroll row: shift rows up, drop the cursor
            // one row, clear from the cursor to the end of the last text row.
            if (mirror_cursor >= SCROLL_LIMIT) begin
                for (i = 0; i < SCROLL_LIMIT - COLUMNS; i++) begin
                    screen_mirror[i] = screen_mirror[i + COLUMNS];
                end
                mirror_cursor = mirror_cursor - COLUMNS;
                for (i = mirror_cursor; i < SCROLL_LIMIT; i++) begin
                    screen_mirror[i] = '0;
                end
                scroll_count++;
            end
            screen_mirror[mirror_cursor] = tmcw_pkg::BLANK_CELL;
            put_count++;
        end else begin
            // reads past the store come back as zero
            if (w.cell_index < CELLS) r.cell_data = screen_mirror[w.cell_index];
            read_count++;
        end
        r.cursor_pos = mirror_cursor[tmcw_pkg::IDX_W-1:0];
        return r;
    endfunction

    function automatic t_table_row make_row(input logic op, input int code, input int idx,
                                            input bit typed, input int cur, input int data);
        t_table_row row;
        row.cmd.opcode      = op;
        row.cmd.char_code   = code[tmcw_pkg::CODE_W-1:0];
        row.cmd.cell_index  = idx[tmcw_pkg::IDX_W-1:0];
        row.typed           = typed;
        row.want.cursor_pos = cur[tmcw_pkg::IDX_W-1:0];
        row.want.cell_data  = data[tmcw_pkg::CELL_W-1:0];
        return row;
    endfunction

    // Mostly text: printable runs, line breaks and some backspaces, with reads
    // aimed near the cursor, at the bottom rows or anywhere; the rest is any code at all.
    function automatic tmcw_pkg::t_in_word random_word();
        tmcw_pkg::t_in_word w;
        int                 pick;
        int                 lo;
        w.opcode     = tmcw_pkg::OP_PUT;
        w.char_code  = tmcw_pkg::CODE_W'($urandom_range(0, (1 << tmcw_pkg::CODE_W) - 1));
        w.cell_index = tmcw_pkg::IDX_W'($urandom_range(0, INDEX_MAX));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            w.opcode = tmcw_pkg::OP_READ;
            if (pick < 8) begin
                lo = mirror_cursor - 100;
                if (lo < 0) lo = 0;
                w.cell_index = tmcw_pkg::IDX_W'($urandom_range(lo, mirror_cursor));
            end else if (pick < 11) begin
                w.cell_index =
                    tmcw_pkg::IDX_W'($urandom_range(SCROLL_LIMIT - COLUMNS, INDEX_MAX));
            end
        end else if (pick < 33) begin
            w.char_code = tmcw_pkg::CODE_NEWLINE;
        end else if (pick < 42) begin
            w.char_code = tmcw_pkg::CODE_BACKSPACE;
        end else if (pick < 70) begin
            w.char_code = tmcw_pkg::CODE_W'($urandom_range(8'h20, 8'h7e));
        end
        return w;
    endfunction

    // Hold start high with the word until an edge sees busy low, then log
    // what that word should return.
    task automatic issue_word(input tmcw_pkg::t_in_word w, input bit typed,
                              input tmcw_pkg::t_out_word want);
        tmcw_pkg::t_out_word guess;
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        guess = console_step(w);
        awaited_words.push_back(typed ? want : guess);
    endtask

    // Result words cannot be held off: capture each one on the edge ending
    // its strobe cycle and match it against the oldest awaited word.
    always @(posedge i_clk) begin
        tmcw_pkg::t_out_word want;
        if (i_rst_n && o_done) begin
            if (awaited_words.size() == 0) begin
                $display("%0t: result word with none awaited: cursor %0d data %h",
                         $time, o_result.cursor_pos, o_result.cell_data);
                error_count++;
            end else begin
                want = awaited_words.pop_front();
                checked_count++;
                if (o_result.cursor_pos !== want.cursor_pos) begin
                    $display("%0t: word %0d cursor_pos expected %0d got %0d",
                             $time, checked_count, want.cursor_pos, o_result.cursor_pos);
                    error_count++;
                end
                if (o_result.cell_data !== want.cell_data) begin
                    $display("%0t: word %0d cell_data expected %h got %h",
                             $time, checked_count, want.cell_data, o_result.cell_data);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_table_row steps [$];
        int         burst;
        int         gap;
        int         sent;
        int         k;

        foreach (screen_mirror[i]) screen_mirror[i] = '0;
        mirror_cursor = 0;
        put_count     = 0;
        read_count    = 0;
        scroll_count  = 0;
        checked_count = 0;
        error_count   = 0;

        // Fresh store reads zero, inside and past the end of the screen.
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 0, 1, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, INDEX_MAX, 1, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 9'h1ff, CELLS - 1, 1, 0, 0));
        // Backspace at the home position stays put.
        steps.push_back(make_row(tmcw_pkg::OP_PUT, tmcw_pkg::CODE_BACKSPACE, 0, 1, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_PUT, 8'h41, 0, 1, 1, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 0, 1, 1, 16'h0741));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 1, 1, 1, 16'h0720));
        // Top code stores its low byte only.
        steps.push_back(make_row(tmcw_pkg::OP_PUT, 9'h1ff, 0, 1, 2, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 1, 1, 2, 16'h07ff));
        steps.push_back(make_row(tmcw_pkg::OP_PUT, 0, 0, 1, 3, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 2, 1, 3, 16'h0700));
        // Backspace lays a blank over the cell it backs onto.
        steps.push_back(make_row(tmcw_pkg::OP_PUT, tmcw_pkg::CODE_BACKSPACE, 0, 1, 2, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 2, 1, 2, 16'h0720));
        steps.push_back(make_row(tmcw_pkg::OP_PUT, tmcw_pkg::CODE_NEWLINE, 0, 1, 80, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 80, 1, 80, 16'h0720));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 2, 0, 0, 0));
        // Low byte equal to newline but above 256: an ordinary character.
        steps.push_back(make_row(tmcw_pkg::OP_PUT, 9'h10a, 0, 1, 81, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, 80, 1, 81, 16'h070a));
        steps.push_back(make_row(tmcw_pkg::OP_PUT, 8'hff, INDEX_MAX, 1, 82, 0));
        steps.push_back(make_row(tmcw_pkg::OP_PUT, tmcw_pkg::CODE_BACKSPACE, 0, 0, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 9'h1ff, SCROLL_LIMIT - 1, 0, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, SCROLL_LIMIT, 0, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, 0, CELLS, 0, 0, 0));
        steps.push_back(make_row(tmcw_pkg::OP_READ, tmcw_pkg::CODE_BACKSPACE, 11'h400,
                                 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its store after reset; the handshake waits it out.
        foreach (steps[i]) issue_word(steps[i].cmd, steps[i].typed, steps[i].want);

        // Random bursts; a quarter of the bursts run straight into the next.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
                issue_word(random_word(), 1'b0, '0);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (gap == 0) start <= 1'b0;

        // Drain: every awaited word must come back, then watch a few more edges.
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d puts with %0d scrolls and %0d reads; %0d result words checked.",
                 put_count, scroll_count, read_count, checked_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Worst case is every word forcing a scroll.
    initial begin
        #50_000_000;
        $display("Timed out with %0d result words outstanding.", awaited_words.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
